[hdl/bfsc_pkg.sv]
// ----------------------------------------------------------------------------
// bfsc_pkg
// Shared constants, types and operation codes of the bit map find core.
// ----------------------------------------------------------------------------
package bfsc_pkg;

    localparam int MAP_BITS   = 1024;
    localparam int WORD_BITS  = 32;
    localparam int WORD_COUNT = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int ADDR_W     = $clog2(WORD_COUNT);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int INDEX_W    = 10;
    localparam int SIZE_W     = 11;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [ADDR_W-1:0]    addr_t;

    typedef enum logic [2:0] {
        OP_TEST       = 3'd0,
        OP_SET        = 3'd1,
        OP_CLEAR      = 3'd2,
        OP_SET_ALL    = 3'd3,
        OP_CLEAR_ALL  = 3'd4,
        OP_FIND_SET   = 3'd5,
        OP_FIND_CLEAR = 3'd6
    } op_t;

    typedef struct packed {
        logic  rd_en;
        addr_t rd_addr;
        logic  wr_en;
        addr_t wr_addr;
        word_t wr_data;
    } mem_req_t;

endpackage

[hdl/bitmap_find_first_set_clear_core.sv]
// ----------------------------------------------------------------------------
// bitmap_find_first_set_clear_core
// Bit map with single-bit test, set and clear, fill, and find first set/clear.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low; its result shows
// on the result ports for one cycle with done high and must be taken then.
// Each cycle the word memory does at most one read or one write, which sets
// the time per operation. Test, set and clear read the word, then test the
// bit or write the word back; an out-of-range index, an unknown code and any
// operation on an empty map finish from idle. Set all and clear all write
// each word in use in turn. A find reads one word a cycle and stops at the
// first matching word. The map reads as all zeros after reset.
module bitmap_find_first_set_clear_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    operation,
    input  logic [bfsc_pkg::INDEX_W-1:0]  bit_index,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bfsc_pkg::SIZE_W-1:0]   cfg_data,
    output logic                          done,
    output logic                          bit_value,
    output logic                          found,
    output logic [bfsc_pkg::INDEX_W-1:0]  found_index,
    output logic                          range_error
);
    import bfsc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RMW  = 4'b0010,
        ST_FILL = 4'b0100,
        ST_SCAN = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [INDEX_W-1:0] idx_reg, idx_next;
    logic [SIZE_W-1:0]  size_reg, size_next;
    logic [CNT_W-1:0]   words_reg, words_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SIZE_W-1:0]  bits_in_use_reg;
    logic               done_reg, done_next;
    logic               bit_value_reg, bit_value_next;
    logic               found_reg, found_next;
    logic [INDEX_W-1:0] found_index_reg, found_index_next;
    logic               range_error_reg, range_error_next;

    logic [SIZE_W-1:0]  size_now;
    logic [SIZE_W:0]    size_round;
    logic [CNT_W-1:0]   words_now;
    logic [CNT_W-1:0]   cnt_inc;
    logic               accept;
    logic               idx_ok;
    logic [BIT_W-1:0]   bit_sel;
    word_t              bit_mask;
    word_t              scan_word;
    logic               scan_any;
    logic [BIT_W-1:0]   scan_pos;
    logic [INDEX_W-1:0] scan_index;
    mem_req_t           req;
    word_t              rd_data;

    bfsc_word_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_data (rd_data)
    );

    bfsc_lowest_bit u_lowest
    (
        .word (scan_word),
        .any  (scan_any),
        .pos  (scan_pos)
    );

    assign cfg_ready  = 1'b1;
    assign busy       = (state_reg != ST_IDLE);
    assign accept     = start && (state_reg == ST_IDLE);
    assign size_now   = (bits_in_use_reg > SIZE_W'(MAP_BITS)) ? SIZE_W'(MAP_BITS)
                                                               : bits_in_use_reg;
    assign size_round = {1'b0, size_now} + (SIZE_W + 1)'(WORD_BITS - 1);
    assign words_now  = CNT_W'(size_round >> BIT_W);
    assign idx_ok     = ({1'b0, bit_index} < size_now);
    assign cnt_inc    = cnt_reg + CNT_W'(1);
    assign bit_sel    = idx_reg[BIT_W-1:0];
    assign bit_mask   = word_t'(1) << bit_sel;
    assign scan_word  = (op_reg == OP_FIND_SET) ? rd_data : ~rd_data;
    assign scan_index = {cnt_reg[ADDR_W-1:0], scan_pos};

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        idx_next         = idx_reg;
        size_next        = size_reg;
        words_next       = words_reg;
        cnt_next         = cnt_reg;
        done_next        = 1'b0;
        bit_value_next   = 1'b0;
        found_next       = 1'b0;
        found_index_next = '0;
        range_error_next = 1'b0;
        req              = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next    = op_t'(operation);
                    idx_next   = bit_index;
                    size_next  = size_now;
                    words_next = words_now;
                    cnt_next   = '0;
                    case (op_t'(operation))
                        OP_TEST, OP_SET, OP_CLEAR:
                        begin
                            if (!idx_ok)
                            begin
                                done_next        = 1'b1;
                                range_error_next = 1'b1;
                            end
                            else
                            begin
                                req.rd_en   = 1'b1;
                                req.rd_addr = ADDR_W'(bit_index >> BIT_W);
                                state_next  = ST_RMW;
                            end
                        end
                        OP_SET_ALL, OP_CLEAR_ALL:
                        begin
                            if (words_now == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_FILL;
                            end
                        end
                        OP_FIND_SET, OP_FIND_CLEAR:
                        begin
                            if (words_now == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                req.rd_en   = 1'b1;
                                req.rd_addr = '0;
                                state_next  = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_RMW:
            begin
                if (op_reg == OP_TEST)
                begin
                    bit_value_next = rd_data[bit_sel];
                end
                else
                begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = ADDR_W'(idx_reg >> BIT_W);
                    req.wr_data = (op_reg == OP_SET) ? (rd_data | bit_mask)
                                                     : (rd_data & ~bit_mask);
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_FILL:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = cnt_reg[ADDR_W-1:0];
                req.wr_data = (op_reg == OP_SET_ALL) ? '1 : '0;
                cnt_next    = cnt_inc;
                if (cnt_inc == words_reg)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (scan_any)
                begin
                    if ({1'b0, scan_index} < size_reg)
                    begin
                        found_next       = 1'b1;
                        found_index_next = scan_index;
                    end
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (cnt_inc == words_reg)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = cnt_inc[ADDR_W-1:0];
                    cnt_next    = cnt_inc;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            done_reg        <= 1'b0;
            bits_in_use_reg <= SIZE_W'(MAP_BITS);
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                bits_in_use_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        idx_reg         <= idx_next;
        size_reg        <= size_next;
        words_reg       <= words_next;
        bit_value_reg   <= bit_value_next;
        found_reg       <= found_next;
        found_index_reg <= found_index_next;
        range_error_reg <= range_error_next;
    end

    assign done        = done_reg;
    assign bit_value   = bit_value_reg;
    assign found       = found_reg;
    assign found_index = found_index_reg;
    assign range_error = range_error_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> ({1'b0, found_index} < size_reg))
        else $error("Reported index lies beyond the valid size.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && range_error) |-> (!found && !bit_value))
        else $error("Range error reported together with a bit or find result.");

    assert property (@(posedge clk) disable iff (!rst_n)
        req.wr_en |-> ((state_reg == ST_RMW && op_reg != OP_TEST) || state_reg == ST_FILL))
        else $error("Memory write outside a modify or fill step.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> (cnt_reg < words_reg))
        else $error("Fill went past the words in use.");
`endif

endmodule

[hdl/bfsc_word_store.sv]
// ----------------------------------------------------------------------------
// bfsc_word_store
// Word memory of the bit map with one write and one registered read port.
// ----------------------------------------------------------------------------
module bfsc_word_store
(
    input  logic              clk,
    input  logic              rst_n,
    input  bfsc_pkg::mem_req_t req,
    output bfsc_pkg::word_t   rd_data
);
    import bfsc_pkg::*;

    word_t                 mem [WORD_COUNT];
    logic [WORD_COUNT-1:0] valid_reg;
    word_t                 rd_data_reg;

    // A word that was never written since reset reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.wr_en)
        begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= valid_reg[req.rd_addr] ? mem[req.rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/bfsc_lowest_bit.sv]
// ----------------------------------------------------------------------------
// bfsc_lowest_bit
// Finds the position of the lowest set bit of one map word.
// ----------------------------------------------------------------------------
module bfsc_lowest_bit
(
    input  bfsc_pkg::word_t           word,
    output logic                      any,
    output logic [bfsc_pkg::BIT_W-1:0] pos
);
    import bfsc_pkg::*;

    word_t            rest;
    logic [BIT_W-1:0] pos_acc;

    // Halving search: each step drops the lower half when it is all zero.
    always_comb
    begin
        rest    = word;
        pos_acc = '0;
        for (int s = BIT_W - 1; s >= 0; s--)
        begin
            if ((rest & ((word_t'(1) << (1 << s)) - word_t'(1))) == '0)
            begin
                rest       = rest >> (1 << s);
                pos_acc[s] = 1'b1;
            end
        end
    end

    assign any = (word != '0);
    assign pos = pos_acc;

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bit map find core. A local mirror of the map
// and its size register predicts every result, including fills, finds that
// must skip padding bits, range errors and the unknown code. Directed tests
// cover the corner sizes, then random traffic runs over several map sizes.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bfsc_pkg::*;

    localparam logic [2:0] OP_UNKNOWN   = 3'd7;
    localparam int         WDOG_LIMIT   = 4000;
    localparam int         DRAIN_CYCLES = 40;

    typedef struct {
        logic               bit_value;
        logic               found;
        logic [INDEX_W-1:0] found_index;
        logic               range_error;
    } map_result_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         operation;
    logic [INDEX_W-1:0] bit_index;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [SIZE_W-1:0]  cfg_data;
    logic               done;
    logic               bit_value;
    logic               found;
    logic [INDEX_W-1:0] found_index;
    logic               range_error;

    word_t              map_mirror [WORD_COUNT];
    logic [SIZE_W-1:0]  size_mirror;
    map_result_t        pending_results [$];

    bit                 idle_enabled;
    int                 error_count;
    int                 ops_accepted;
    int                 results_seen;
    int                 finds_located;
    int                 range_faults;
    int                 size_writes;
    int                 quiet_cycles;

    bitmap_find_first_set_clear_core dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .bit_index   (bit_index),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .done        (done),
        .bit_value   (bit_value),
        .found       (found),
        .found_index (found_index),
        .range_error (range_error)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic map_result_t predict_map(logic [2:0] op, logic [INDEX_W-1:0] idx);
        map_result_t res;
        int unsigned span;
        int unsigned word_cnt;
        int unsigned pos;
        logic        want;
        logic        scanning;
        logic        hit;
        word_t       word;
        res = '{default: 1'b0};
        span = (size_mirror > MAP_BITS) ? MAP_BITS : size_mirror;
        word_cnt = (span + WORD_BITS - 1) / WORD_BITS;
        case (op)
            OP_TEST, OP_SET, OP_CLEAR:
            begin
                if (idx >= span)
                    res.range_error = 1'b1;
                else if (op == OP_TEST)
                    res.bit_value = map_mirror[idx / WORD_BITS][idx % WORD_BITS];
                else
                    map_mirror[idx / WORD_BITS][idx % WORD_BITS] = (op == OP_SET);
            end
            OP_SET_ALL, OP_CLEAR_ALL:
            begin
                for (int w = 0; w < word_cnt; w++)
                    map_mirror[w] = (op == OP_SET_ALL) ? '1 : '0;
            end
            OP_FIND_SET, OP_FIND_CLEAR:
            begin
                want = (op == OP_FIND_SET);
                scanning = 1'b1;
                for (int w = 0; w < word_cnt && scanning; w++)
                begin
                    word = map_mirror[w];
                    if (want ? (word != '0) : (word != '1))
                    begin
                        scanning = 1'b0;
                        hit = 1'b0;
                        for (int b = 0; b < WORD_BITS && !hit; b++)
                        begin
                            if (word[b] == want)
                            begin
                                hit = 1'b1;
                                pos = w * WORD_BITS + b;
                                if (pos < span)
                                begin
                                    res.found = 1'b1;
                                    res.found_index = pos[INDEX_W-1:0];
                                end
                            end
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    task automatic check_field(string name, logic [INDEX_W-1:0] exp_v,
                               logic [INDEX_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                size_mirror = cfg_data;
            if (start && !busy)
            begin
                pending_results.push_back(predict_map(operation, bit_index));
                ops_accepted++;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        map_result_t want_r;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: result transfer with no operation outstanding", $time);
                error_count++;
            end
            else
            begin
                want_r = pending_results.pop_front();
                check_field("bit_value", INDEX_W'(want_r.bit_value), INDEX_W'(bit_value));
                check_field("found", INDEX_W'(want_r.found), INDEX_W'(found));
                check_field("found_index", want_r.found_index, found_index);
                check_field("range_error", INDEX_W'(want_r.range_error),
                            INDEX_W'(range_error));
                results_seen++;
                if (want_r.found)
                    finds_located++;
                if (want_r.range_error)
                    range_faults++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WDOG_LIMIT)
                begin
                    $display("%0t ns: no transfer for %0d cycles", $time, quiet_cycles);
                    $display("*** FAILED ***");
                    $finish;
                end
            end
        end
    end

    task automatic send_op(logic [2:0] op, logic [INDEX_W-1:0] idx);
        int gap;
        @(negedge clk);
        if (idle_enabled && $urandom_range(99) < 30)
        begin
            gap = ($urandom_range(3) == 0) ? $urandom_range(1, 36) : $urandom_range(1, 3);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start     <= 1'b1;
        operation <= op;
        bit_index <= idx;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_size(logic [SIZE_W-1:0] value);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        size_writes++;
    endtask

    task automatic test_bit_ops();
        send_op(OP_TEST, 10'd0);
        send_op(OP_SET, 10'd0);
        send_op(OP_TEST, 10'd0);
        send_op(OP_SET, 10'd1023);
        send_op(OP_TEST, 10'd1023);
        send_op(OP_FIND_SET, 10'd0);
        send_op(OP_CLEAR, 10'd0);
        send_op(OP_FIND_SET, 10'd0);
        send_op(OP_FIND_CLEAR, 10'd0);
        send_op(OP_UNKNOWN, 10'h3FF);
    endtask

    task automatic test_fill_find();
        send_op(OP_SET_ALL, 10'd0);
        send_op(OP_FIND_CLEAR, 10'd0);
        send_op(OP_CLEAR, 10'd700);
        send_op(OP_FIND_CLEAR, 10'd0);
        send_op(OP_CLEAR_ALL, 10'd0);
        send_op(OP_FIND_SET, 10'd0);
    endtask

    task automatic test_size_limits();
        write_size(11'd0);
        send_op(OP_TEST, 10'd0);
        send_op(OP_SET_ALL, 10'd0);
        send_op(OP_FIND_SET, 10'd0);
        write_size(11'd40);
        send_op(OP_SET, 10'd40);
        send_op(OP_SET_ALL, 10'd0);
        send_op(OP_FIND_CLEAR, 10'd0);
        write_size(11'd2047);
        send_op(OP_FIND_CLEAR, 10'd0);
        send_op(OP_CLEAR_ALL, 10'd0);
        send_op(OP_SET, 10'd50);
        send_op(OP_TEST, 10'd1023);
        write_size(11'd40);
        send_op(OP_FIND_SET, 10'd0);
        write_size(11'd1);
        send_op(OP_SET, 10'd0);
        send_op(OP_TEST, 10'd0);
        send_op(OP_FIND_CLEAR, 10'd0);
        write_size(11'd1024);
    endtask

    function automatic logic [2:0] pick_op();
        int r;
        r = $urandom_range(99);
        if (r < 20)
            return OP_TEST;
        else if (r < 40)
            return OP_SET;
        else if (r < 58)
            return OP_CLEAR;
        else if (r < 73)
            return OP_FIND_SET;
        else if (r < 88)
            return OP_FIND_CLEAR;
        else if (r < 92)
            return OP_SET_ALL;
        else if (r < 96)
            return OP_CLEAR_ALL;
        return OP_UNKNOWN;
    endfunction

    task automatic test_random_traffic();
        int          phase_size [7];
        int unsigned span;
        int          count;
        logic [INDEX_W-1:0] idx;
        phase_size = '{1024, 33, 1, 0, 2047, 0, 0};
        phase_size[5] = $urandom_range(2, 1023);
        phase_size[6] = $urandom_range(1025, 2046);
        for (int p = 0; p < 7; p++)
        begin
            write_size(phase_size[p][SIZE_W-1:0]);
            span = (phase_size[p] > MAP_BITS) ? MAP_BITS : phase_size[p];
            count = (phase_size[p] == 0) ? 50 : 225;
            idle_enabled = (p != 4);
            for (int i = 0; i < count; i++)
            begin
                if (span > 0 && $urandom_range(99) < 85)
                    idx = INDEX_W'($urandom_range(span - 1));
                else
                    idx = INDEX_W'($urandom_range(MAP_BITS - 1));
                send_op(pick_op(), idx);
                if ($urandom_range(63) == 0)
                    wait_idle();
            end
        end
        idle_enabled = 1'b1;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        operation    = OP_TEST;
        bit_index    = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        idle_enabled = 1'b1;
        error_count  = 0;
        ops_accepted = 0;
        results_seen = 0;
        finds_located = 0;
        range_faults = 0;
        size_writes  = 0;
        quiet_cycles = 0;
        size_mirror  = SIZE_W'(MAP_BITS);
        foreach (map_mirror[w])
            map_mirror[w] = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        test_bit_ops();
        test_fill_find();
        test_size_limits();
        test_random_traffic();
        write_size(11'd1024);
        wait_idle();

        $display("Run covered %0d operations and %0d results over %0d map size writes.",
                 ops_accepted, results_seen, size_writes);
        $display("Finds located %0d bits and %0d accesses fell outside the map.",
                 finds_located, range_faults);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
